// ===== rtl/ordered_slot_array_macros.svh =====
// Assertion macros shared by the ordered slot array RTL.
`ifndef ORDERED_SLOT_ARRAY_MACROS_SVH
`define ORDERED_SLOT_ARRAY_MACROS_SVH
`ifndef SYNTHESIS
// Plain property check, disabled while reset is high.
`define OSA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ordered_slot_array check failed");
// Implication check: when cond holds, prop must hold in the same cycle.
`define OSA_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ordered_slot_array check failed");
`else
`define OSA_ASSERT(label, clk, rst, prop)
`define OSA_ASSERT_IMP(label, clk, rst, cond, prop)
`endif
`endif

// ===== rtl/osa_pkg.sv =====
// Types and constants shared by the ordered slot array modules.
package osa_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int CAP_RESET     = 64;
   localparam int WORD_W        = 64;
   localparam int FIELD_W       = 7;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_ERASE   = 2'd1,
      OP_REVERSE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Action that all cells of the chain apply together.
   typedef enum logic [2:0] {
      CELL_HOLD        = 3'd0,
      CELL_INSERT      = 3'd1,
      CELL_SHIFT_DOWN  = 3'd2,
      CELL_ROTATE      = 3'd3,
      CELL_PROBE_LOAD  = 3'd4,
      CELL_PROBE_SHIFT = 3'd5
   } cell_op_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      SEQ_IDLE   = 2'd0,
      SEQ_RUN    = 2'd1,
      SEQ_FINISH = 2'd2
   } seq_state_type;

   typedef struct packed {
      op_type              operation;
      logic [FIELD_W-1:0]  position;
      logic [FIELD_W-1:0]  run_length;
      logic [WORD_W-1:0]   entry_value;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [FIELD_W-1:0]  length;
      logic [WORD_W-1:0]   read_value;
   } rsp_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      cell_op_type         op;
      logic [WORD_W-1:0]   bus;
   } cell_ctrl_type;

endpackage

// ===== rtl/osa_cell.sv =====
// One slot of the chain: holds an entry and a probe word, trades with neighbors.
module osa_cell #(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  logic                          clock,
   input  osa_pkg::cell_ctrl_type        ctrl,
   input  logic [CW-1:0]                 bnd,
   input  logic [osa_pkg::WORD_W-1:0]    left_entry,
   input  logic [osa_pkg::WORD_W-1:0]    right_entry,
   input  logic [osa_pkg::WORD_W-1:0]    right_probe,
   output logic [osa_pkg::WORD_W-1:0]    entry,
   output logic [osa_pkg::WORD_W-1:0]    probe
);

   localparam logic [CW-1:0] SELF = CW'(IDX);

   logic [osa_pkg::WORD_W-1:0] entry_ff, entry_in;
   logic [osa_pkg::WORD_W-1:0] probe_ff, probe_in;

   // Select the next entry and probe word from this slot's place against the boundary.
   always_comb begin
      entry_in = entry_ff;
      probe_in = probe_ff;
      unique case (ctrl.op)
         osa_pkg::CELL_HOLD: begin
            entry_in = entry_ff;
         end
         osa_pkg::CELL_INSERT: begin
            if (SELF > bnd) begin
               entry_in = left_entry;
            end else if (SELF == bnd) begin
               entry_in = ctrl.bus;
            end
         end
         osa_pkg::CELL_SHIFT_DOWN: begin
            if (SELF >= bnd) begin
               entry_in = right_entry;
            end
         end
         osa_pkg::CELL_ROTATE: begin
            if (SELF < bnd) begin
               entry_in = right_entry;
            end else if (SELF == bnd) begin
               entry_in = ctrl.bus;
            end
         end
         osa_pkg::CELL_PROBE_LOAD: begin
            probe_in = (SELF == bnd) ? entry_ff : '0;
         end
         osa_pkg::CELL_PROBE_SHIFT: begin
            probe_in = right_probe;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Slot storage; contents are undefined until written.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      probe_ff <= probe_in;
   end

   assign entry = entry_ff;
   assign probe = probe_ff;

endmodule

// ===== rtl/osa_seq.sv =====
// Sequencer: request checks, length and capacity, step control and response register.
`include "ordered_slot_array_macros.svh"

module osa_seq #(
   parameter int DEPTH = osa_pkg::DEPTH_DEFAULT,
   parameter int CW    = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  osa_pkg::req_type              req_data,
   output logic                          req_stall,
   output logic                          rsp_valid,
   output osa_pkg::rsp_type              rsp_data,
   input  logic                          rsp_stall,
   input  logic                          csr_wen,
   input  logic [osa_pkg::FIELD_W-1:0]   csr_wdata,
   input  logic [osa_pkg::WORD_W-1:0]    cell0_entry,
   input  logic [osa_pkg::WORD_W-1:0]    cell0_probe,
   output osa_pkg::cell_ctrl_type        ctrl,
   output logic [CW-1:0]                 bnd
);

   localparam int CAP_INIT = (osa_pkg::CAP_RESET > DEPTH) ? DEPTH : osa_pkg::CAP_RESET;

   osa_pkg::seq_state_type state_ff, state_in;

   logic [CW-1:0]              cap_ff, cap_in;
   logic [CW-1:0]              count_ff, count_in;
   osa_pkg::op_type            op_ff;
   logic [CW-1:0]              bnd_ff, bnd_in;
   logic [CW-1:0]              steps_ff, steps_in;
   logic                       first_ff;
   osa_pkg::status_type        status_ff;
   logic [osa_pkg::WORD_W-1:0] value_ff;
   logic                       rsp_valid_ff;
   osa_pkg::rsp_type           rsp_data_ff;

   logic                       accept;
   logic                       rsp_load;
   osa_pkg::status_type        chk_status;
   logic [CW-1:0]              chk_count;
   logic [CW-1:0]              chk_steps;
   logic [CW-1:0]              chk_bnd;
   logic [CW-1:0]              pos_w;
   logic [CW-1:0]              run_w;
   logic [CW:0]                pos_run_sum;
   logic [CW-1:0]              wr_cap;

   assign accept   = req_valid && !req_stall;
   assign rsp_load = (state_ff == osa_pkg::SEQ_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign pos_w    = CW'(req_data.position);
   assign run_w    = CW'(req_data.run_length);
   assign pos_run_sum = {1'b0, pos_w} + {1'b0, run_w};
   assign wr_cap   = (CW'(csr_wdata) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(csr_wdata);

   // Check the request against the current length and capacity and work out the step count.
   always_comb begin
      chk_status = osa_pkg::ST_DONE;
      chk_count  = count_ff;
      chk_steps  = '0;
      chk_bnd    = pos_w;
      unique case (req_data.operation)
         osa_pkg::OP_INSERT: begin
            if (({1'b0, count_ff} + 1'b1) > {1'b0, cap_ff}) begin
               chk_status = osa_pkg::ST_FULL;
            end else if (pos_w > count_ff) begin
               chk_status = osa_pkg::ST_RANGE;
            end else begin
               chk_steps = CW'(1);
               chk_count = count_ff + 1'b1;
            end
         end
         osa_pkg::OP_ERASE: begin
            if (pos_run_sum > {1'b0, count_ff}) begin
               chk_status = osa_pkg::ST_RANGE;
            end else begin
               chk_steps = run_w;
               chk_count = count_ff - run_w;
            end
         end
         osa_pkg::OP_REVERSE: begin
            if (count_ff >= CW'(2)) begin
               chk_steps = count_ff - 1'b1;
               chk_bnd   = count_ff - 1'b1;
            end
         end
         osa_pkg::OP_READ: begin
            if (pos_w >= count_ff) begin
               chk_status = osa_pkg::ST_RANGE;
            end else begin
               chk_steps = pos_w + 1'b1;
            end
         end
      endcase
   end

   // Next state and the per-cycle command to the cell chain.
   always_comb begin
      state_in = state_ff;
      steps_in = steps_ff;
      bnd_in   = bnd_ff;
      ctrl.op  = osa_pkg::CELL_HOLD;
      ctrl.bus = (op_ff == osa_pkg::OP_REVERSE) ? cell0_entry : value_ff;
      unique case (state_ff)
         osa_pkg::SEQ_IDLE: begin
            if (accept) begin
               steps_in = chk_steps;
               bnd_in   = chk_bnd;
               state_in = (chk_steps == '0) ? osa_pkg::SEQ_FINISH : osa_pkg::SEQ_RUN;
            end
         end
         osa_pkg::SEQ_RUN: begin
            unique case (op_ff)
               osa_pkg::OP_INSERT:  ctrl.op = osa_pkg::CELL_INSERT;
               osa_pkg::OP_ERASE:   ctrl.op = osa_pkg::CELL_SHIFT_DOWN;
               osa_pkg::OP_REVERSE: ctrl.op = osa_pkg::CELL_ROTATE;
               osa_pkg::OP_READ: begin
                  ctrl.op = first_ff ? osa_pkg::CELL_PROBE_LOAD : osa_pkg::CELL_PROBE_SHIFT;
               end
            endcase
            steps_in = steps_ff - 1'b1;
            if (op_ff == osa_pkg::OP_REVERSE) begin
               bnd_in = bnd_ff - 1'b1;
            end
            if (steps_ff == CW'(1)) begin
               state_in = osa_pkg::SEQ_FINISH;
            end
         end
         osa_pkg::SEQ_FINISH: begin
            if (rsp_load) begin
               state_in = osa_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = osa_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Capacity and length: a capacity write empties the array, a zero write is dropped.
   always_comb begin
      cap_in   = cap_ff;
      count_in = count_ff;
      if (csr_wen && (csr_wdata != '0)) begin
         cap_in   = wr_cap;
         count_in = '0;
      end else if (accept) begin
         count_in = chk_count;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= osa_pkg::SEQ_IDLE;
         cap_ff       <= CW'(CAP_INIT);
         count_ff     <= '0;
         steps_ff     <= '0;
         bnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= cap_in;
         count_ff <= count_in;
         steps_ff <= steps_in;
         bnd_ff   <= bnd_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request details and the response word.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.operation;
         status_ff <= chk_status;
         value_ff  <= req_data.entry_value;
         first_ff  <= 1'b1;
      end else if (state_ff == osa_pkg::SEQ_RUN) begin
         first_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff.status <= status_ff;
         rsp_data_ff.length <= count_ff[osa_pkg::FIELD_W-1:0];
         rsp_data_ff.read_value <=
            ((op_ff == osa_pkg::OP_READ) && (status_ff == osa_pkg::ST_DONE)) ?
            cell0_probe : '0;
      end
   end

   assign req_stall = (state_ff != osa_pkg::SEQ_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign bnd       = bnd_ff;

   // Consistency checks on length, capacity, the step counter and the rotate boundary.
   `OSA_ASSERT(a_count_within_cap, clock, reset, count_ff <= cap_ff)
   `OSA_ASSERT(a_cap_legal, clock, reset, (cap_ff != '0) && (cap_ff <= CW'(DEPTH)))
   `OSA_ASSERT_IMP(a_run_has_steps, clock, reset, state_ff == osa_pkg::SEQ_RUN, steps_ff != '0)
   `OSA_ASSERT_IMP(a_rotate_in_range, clock, reset,
      (state_ff == osa_pkg::SEQ_RUN) && (op_ff == osa_pkg::OP_REVERSE), bnd_ff < count_ff)

endmodule

// ===== rtl/ordered_slot_array.sv =====
// A request runs N chain steps in SEQ_RUN; its response is registered from SEQ_FINISH. N is
// 1 for an insert that succeeds, run_length for an erase that succeeds, length-1 for a reverse
// of two or more entries, position+1 for a read that succeeds, and 0 for any other request.
// No new request is taken until the response is registered; rsp_stall can delay it.
// Synchronous active-high reset empties the array and sets capacity to 64 (at most DEPTH);
// slot contents are undefined until written.
module ordered_slot_array #(
   parameter int DEPTH = osa_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  osa_pkg::req_type              req_data,
   output logic                          req_stall,
   output logic                          rsp_valid,
   output osa_pkg::rsp_type              rsp_data,
   input  logic                          rsp_stall,
   input  logic                          csr_wen,
   input  logic [osa_pkg::FIELD_W-1:0]   csr_wdata
);

   localparam int CW = ($clog2(DEPTH + 1) > osa_pkg::FIELD_W) ?
                       $clog2(DEPTH + 1) : osa_pkg::FIELD_W;

   osa_pkg::cell_ctrl_type     ctrl;
   logic [CW-1:0]              bnd;
   logic [osa_pkg::WORD_W-1:0] entry_w [DEPTH];
   logic [osa_pkg::WORD_W-1:0] probe_w [DEPTH];

   // Sequencer.
   osa_seq #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .cell0_entry (entry_w[0]),
      .cell0_probe (probe_w[0]),
      .ctrl        (ctrl),
      .bnd         (bnd)
   );

   // Chain of slots; the ends fall back on their own entry and a zero probe.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [osa_pkg::WORD_W-1:0] left_entry;
      logic [osa_pkg::WORD_W-1:0] right_entry;
      logic [osa_pkg::WORD_W-1:0] right_probe;

      if (i == 0) begin : g_first
         assign left_entry = entry_w[i];
      end else begin : g_inner_left
         assign left_entry = entry_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = entry_w[i];
         assign right_probe = '0;
      end else begin : g_inner_right
         assign right_entry = entry_w[i+1];
         assign right_probe = probe_w[i+1];
      end

      osa_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .bnd         (bnd),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .right_probe (right_probe),
         .entry       (entry_w[i]),
         .probe       (probe_w[i])
      );
   end

endmodule
